/* design/hfcs_pkg.sv */
// Shared constants, codes and helper functions for the fan and clutch sequencer.
package hfcs_pkg;

    localparam int TIME_BITS = 40;

    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;

    typedef logic [TIME_BITS-1:0] t_time;
    typedef logic [2:0]           t_fan;
    typedef logic [1:0]           t_mode;
    typedef logic [2:0]           t_wait;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_HIGH   = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_MED    = 4'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_BAND_LOW    = 4'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HYSTERESIS  = 4'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESPIN     = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLUTCH_REST = 4'd5;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PURGE       = 4'd6;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INSTALLED   = 4'd7;

    // register reset values
    localparam logic [12:0] RST_BAND_HIGH   = 13'd300;
    localparam logic [12:0] RST_BAND_MED    = 13'd200;
    localparam logic [12:0] RST_BAND_LOW    = 13'd100;
    localparam logic [12:0] RST_HYSTERESIS  = 13'd50;
    localparam logic [15:0] RST_PRESPIN     = 16'd3000;
    localparam logic [15:0] RST_CLUTCH_REST = 16'd30000;
    localparam logic [15:0] RST_PURGE       = 16'd10000;
    localparam logic [3:0]  RST_INSTALLED   = 4'hF;

    // fan steps
    localparam t_fan FAN_OFF  = 3'd0;
    localparam t_fan FAN_LOW  = 3'd1;
    localparam t_fan FAN_MED  = 3'd2;
    localparam t_fan FAN_HIGH = 3'd3;
    localparam t_fan FAN_MAX  = 3'd4;

    // status modes
    localparam t_mode MODE_OFF    = 2'd0;
    localparam t_mode MODE_AUTO   = 2'd1;
    localparam t_mode MODE_MANUAL = 2'd2;
    localparam t_mode MODE_PURGE  = 2'd3;

    // wait reasons
    localparam t_wait WAIT_NONE      = 3'd0;
    localparam t_wait WAIT_PURGE     = 3'd1;
    localparam t_wait WAIT_NO_SENSOR = 3'd2;
    localparam t_wait WAIT_FAN_OFF   = 3'd3;
    localparam t_wait WAIT_PRESPIN   = 3'd4;
    localparam t_wait WAIT_LOCKOUT   = 3'd5;

    // highest wired step at or below s, off if none
    function automatic t_fan fall_back(input t_fan s, input logic [3:0] inst);
        t_fan r;
        r = FAN_OFF;
        if (s >= FAN_LOW  && inst[0]) r = FAN_LOW;
        if (s >= FAN_MED  && inst[1]) r = FAN_MED;
        if (s >= FAN_HIGH && inst[2]) r = FAN_HIGH;
        if (s >= FAN_MAX  && inst[3]) r = FAN_MAX;
        return r;
    endfunction

    function automatic t_fan top_step(input logic [3:0] inst);
        return inst[3] ? FAN_MAX : FAN_HIGH;
    endfunction

    // elapsed time, clamped at zero when the clock runs backward
    function automatic t_time since(input t_time now, input t_time stamp);
        logic [TIME_BITS:0] d;
        d = {1'b0, now} - {1'b0, stamp};
        return d[TIME_BITS] ? '0 : d[TIME_BITS-1:0];
    endfunction

endpackage

/* design/hvac_fan_clutch_sequencer.sv */
// Top level of the HVAC fan and compressor clutch sequencer.
//
// One control tick in, one status word out. A tick is captured in an input
// register, the whole decision (purge timing, auto banding with hysteresis,
// manual slider map, installed-step fallback, prespin and rest interlocks)
// is worked out in one pass of logic, and the status lands in a result
// register together with the updated fan, clutch, purge and timestamp state.
// A tick goes through the input register, then the result register, before
// its status is valid. A new tick is taken every cycle unless the consumer
// stalls; the throughput of one word per cycle is set by the single pass
// between the two registers, whose longest path is a 40-bit elapsed-time
// subtract and compare. The result register holds a status while the consumer
// stalls and the input register keeps the next tick, so the input only stalls
// when both are full. The configuration port is always ready; writes to
// indexes above seven are dropped. Configure only while no tick is in flight.
module hvac_fan_clutch_sequencer (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // tick input
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_power_on,
    input  logic                                i_auto_select,
    input  logic signed [7:0]                   i_target_deg,
    input  logic [3:0]                          i_fan_slider,
    input  logic                                i_sensor_ok,
    input  logic signed [14:0]                  i_cabin_centi,
    input  logic [hfcs_pkg::TIME_BITS-1:0]      i_time_ms,
    // status output
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [1:0]                          o_mode_code,
    output logic [2:0]                          o_wait_reason,
    output logic [15:0]                         o_wait_left_ms,
    output logic [2:0]                          o_fan_step_now,
    output logic                                o_clutch_now,
    output logic                                o_cabin_seen,
    output logic signed [14:0]                  o_cabin_report,
    output logic signed [7:0]                   o_target_report,
    output logic signed [14:0]                  o_delta_report,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hfcs_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [hfcs_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import hfcs_pkg::*;

    // ---------------- configuration registers ----------------
    logic [12:0] r_band_high, r_band_med, r_band_low, r_hyst;
    logic [15:0] r_prespin, r_rest_min, r_purge_ms;
    logic [3:0]  r_installed;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_high <= RST_BAND_HIGH;
            r_band_med  <= RST_BAND_MED;
            r_band_low  <= RST_BAND_LOW;
            r_hyst      <= RST_HYSTERESIS;
            r_prespin   <= RST_PRESPIN;
            r_rest_min  <= RST_CLUTCH_REST;
            r_purge_ms  <= RST_PURGE;
            r_installed <= RST_INSTALLED;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_BAND_HIGH:   r_band_high <= i_cfg_data[12:0];
                CFG_BAND_MED:    r_band_med  <= i_cfg_data[12:0];
                CFG_BAND_LOW:    r_band_low  <= i_cfg_data[12:0];
                CFG_HYSTERESIS:  r_hyst      <= i_cfg_data[12:0];
                CFG_PRESPIN:     r_prespin   <= i_cfg_data;
                CFG_CLUTCH_REST: r_rest_min  <= i_cfg_data;
                CFG_PURGE:       r_purge_ms  <= i_cfg_data;
                CFG_INSTALLED:   r_installed <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ---------------- handshake ----------------
    logic in_accept, advance;
    logic r_in_valid, r_out_valid;

    // a tick moves from the input register into the result register
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;

    // ---------------- input register ----------------
    logic               r_power, r_auto, r_sensor;
    logic signed [7:0]  r_target;
    logic [3:0]         r_slider;
    logic signed [14:0] r_cabin;
    t_time              r_now;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= in_accept || (r_in_valid && !advance);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_power  <= i_power_on;
            r_auto   <= i_auto_select;
            r_target <= i_target_deg;
            r_slider <= i_fan_slider;
            r_sensor <= i_sensor_ok;
            r_cabin  <= i_cabin_centi;
            r_now    <= i_time_ms;
        end
    end

    // ---------------- sequencer state ----------------
    t_fan  r_blower_step;
    logic  r_clutch, r_purging;
    t_time r_fan_on_stamp, r_clutch_off_stamp, r_power_off_stamp;

    t_fan  n_blower_step;
    logic  n_clutch, n_purging;
    t_time n_fan_on_stamp, n_clutch_off_stamp, n_power_off_stamp;

    t_mode              n_mode;
    t_wait              n_wait;
    logic [15:0]        n_left;
    logic               n_seen;
    logic signed [14:0] n_cabin_rep, n_delta_rep;

    // ---------------- decision logic ----------------
    logic signed [16:0] delta, drep, neg_hyst;
    logic               ge_high, ge_med, ge_low, le_hyst;
    logic               start_purge, purge_active;
    t_time              purge_el, fan_run, rest_el;
    t_fan               wish_step, new_fan;
    logic               wish_clutch, fan_changed;
    logic               clutch_on_req;  // 1: engage, else drop
    logic               hold;

    localparam logic signed [16:0] CENTI_PER_DEG = 17'sd100;
    localparam logic signed [16:0] DREP_MAX      = 17'sd16383;
    localparam logic signed [16:0] DREP_MIN      = -17'sd16384;

    always_comb begin
        delta = {{2{r_cabin[14]}}, r_cabin} - {{9{r_target[7]}}, r_target} * CENTI_PER_DEG;
        neg_hyst = $signed(17'd0 - {4'd0, r_hyst});
        ge_high  = delta >= $signed({4'd0, r_band_high});
        ge_med   = delta >= $signed({4'd0, r_band_med});
        ge_low   = delta >= $signed({4'd0, r_band_low});
        le_hyst  = delta <= neg_hyst;

        n_blower_step      = r_blower_step;
        n_clutch           = r_clutch;
        n_purging          = r_purging;
        n_fan_on_stamp     = r_fan_on_stamp;
        n_clutch_off_stamp = r_clutch_off_stamp;
        n_power_off_stamp  = r_power_off_stamp;
        n_mode             = MODE_OFF;
        n_wait             = WAIT_NONE;
        n_left             = '0;
        n_seen             = 1'b0;

        start_purge   = !r_purging && (r_blower_step != FAN_OFF);
        purge_active  = r_purging || start_purge;
        purge_el      = start_purge ? '0 : since(r_now, r_power_off_stamp);
        wish_step     = r_blower_step;
        wish_clutch   = r_clutch;
        hold          = 1'b0;
        new_fan       = r_blower_step;
        fan_changed   = 1'b0;
        fan_run       = '0;
        rest_el       = since(r_now, r_clutch_off_stamp);
        clutch_on_req = 1'b0;

        if (!r_power) begin
            // power off: clutch drops now, fan runs on for the purge
            clutch_on_req = 1'b0;
            if (start_purge) begin
                n_power_off_stamp = r_now;
            end
            if (purge_active &&
                purge_el < {{(TIME_BITS-16){1'b0}}, r_purge_ms}) begin
                n_purging = 1'b1;
                n_mode    = MODE_PURGE;
                n_wait    = WAIT_PURGE;
                n_left    = r_purge_ms - purge_el[15:0];
            end else begin
                n_purging = 1'b0;
                new_fan   = FAN_OFF;
            end
        end else begin
            n_purging = 1'b0;
            if (r_auto) begin
                n_mode = MODE_AUTO;
                if (!r_sensor) begin
                    // no reading: hold fan and clutch as they are
                    hold   = 1'b1;
                    n_wait = WAIT_NO_SENSOR;
                end else begin
                    n_seen = 1'b1;
                    if (ge_high)      wish_step = top_step(r_installed);
                    else if (ge_med)  wish_step = FAN_MED;
                    else if (ge_low)  wish_step = FAN_LOW;
                    else if (le_hyst) wish_step = FAN_LOW;
                    if (ge_low)       wish_clutch = 1'b1;
                    else if (le_hyst) wish_clutch = 1'b0;
                end
            end else begin
                n_mode = MODE_MANUAL;
                n_seen = r_sensor;
                case (r_slider) inside
                    4'd0:         wish_step = FAN_OFF;
                    [4'd1:4'd2]:  wish_step = FAN_LOW;
                    4'd3:         wish_step = FAN_MED;
                    4'd4:         wish_step = FAN_HIGH;
                    default:      wish_step = top_step(r_installed);
                endcase
                wish_clutch = (wish_step != FAN_OFF);
            end

            if (hold) begin
                clutch_on_req = r_clutch;
            end else begin
                new_fan     = fall_back(wish_step, r_installed);
                fan_changed = (new_fan != r_blower_step);
                // a step change restarts the prespin clock
                fan_run     = fan_changed ? '0 : since(r_now, r_fan_on_stamp);
                if (!wish_clutch) begin
                    clutch_on_req = 1'b0;
                end else if (new_fan == FAN_OFF) begin
                    clutch_on_req = 1'b0;
                    n_wait        = WAIT_FAN_OFF;
                end else if (fan_run < {{(TIME_BITS-16){1'b0}}, r_prespin}) begin
                    clutch_on_req = 1'b0;
                    n_wait        = WAIT_PRESPIN;
                    n_left        = r_prespin - fan_run[15:0];
                end else if (!r_clutch && r_clutch_off_stamp != '0 &&
                             rest_el < {{(TIME_BITS-16){1'b0}}, r_rest_min}) begin
                    // anti short cycle lockout, stamp zero reads as never
                    clutch_on_req = 1'b0;
                    n_wait        = WAIT_LOCKOUT;
                    n_left        = r_rest_min - rest_el[15:0];
                end else begin
                    clutch_on_req = 1'b1;
                end
            end
        end

        // fan step update
        if (new_fan != r_blower_step) begin
            n_blower_step  = new_fan;
            n_fan_on_stamp = (new_fan == FAN_OFF) ? '0 : r_now;
        end
        // clutch update, off edge stamps the rest timer
        n_clutch = clutch_on_req;
        if (r_clutch && !clutch_on_req) begin
            n_clutch_off_stamp = r_now;
        end

        // report fields
        n_cabin_rep = n_seen ? r_cabin : '0;
        drep        = n_seen ? delta : '0;
        if (drep > DREP_MAX)      n_delta_rep = DREP_MAX[14:0];
        else if (drep < DREP_MIN) n_delta_rep = DREP_MIN[14:0];
        else                      n_delta_rep = drep[14:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blower_step      <= FAN_OFF;
            r_clutch           <= 1'b0;
            r_purging          <= 1'b0;
            r_fan_on_stamp     <= '0;
            r_clutch_off_stamp <= '0;
            r_power_off_stamp  <= '0;
        end else if (advance) begin
            r_blower_step      <= n_blower_step;
            r_clutch           <= n_clutch;
            r_purging          <= n_purging;
            r_fan_on_stamp     <= n_fan_on_stamp;
            r_clutch_off_stamp <= n_clutch_off_stamp;
            r_power_off_stamp  <= n_power_off_stamp;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= advance || (r_out_valid && i_out_stall);
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            o_mode_code     <= n_mode;
            o_wait_reason   <= n_wait;
            o_wait_left_ms  <= n_left;
            o_fan_step_now  <= n_blower_step;
            o_clutch_now    <= n_clutch;
            o_cabin_seen    <= n_seen;
            o_cabin_report  <= n_cabin_rep;
            o_target_report <= r_target;
            o_delta_report  <= n_delta_rep;
        end
    end

    // ---------------- assertions ----------------
    // clutch never stays engaged with the blower stopped
    a_clutch_needs_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clutch |-> (r_blower_step != FAN_OFF))
        else $error("clutch engaged with fan off");

    // a purge only runs while the blower is still on
    a_purge_needs_fan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_purging |-> (r_blower_step != FAN_OFF))
        else $error("purge active with fan off");

    // a purge status word always carries the purge wait reason and no clutch
    a_purge_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_mode_code == MODE_PURGE) |->
            (o_wait_reason == WAIT_PURGE && !o_clutch_now))
        else $error("purge status inconsistent");

    // state only moves when a tick is handed to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> ($stable(r_blower_step) && $stable(r_clutch) && $stable(r_purging)))
        else $error("sequencer state changed without a tick");

endmodule
